[sv/qrk_pkg.sv]
// Shared constants for the ordered key queue with removal by key.
`timescale 1ns / 1ps

package qrk_pkg;

    // Queue depth, 1 to 64 entries.
    localparam int QUEUE_DEPTH = 8;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W    = 14;
    localparam int STATUS_W = 3;
    localparam int MOVED_W  = 3;
    localparam int OCC_W    = 4;

    // Occupancy as reported on the result port, saturated at 15.
    localparam int OCC_FULL = (QUEUE_DEPTH > 15) ? 15 : QUEUE_DEPTH;

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PUSHED        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL          = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED_FRONT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED_MOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 3'd4;

endpackage

[sv/queue_remove_by_key.sv]
// Top level: ordered key queue with removal by key, held in one synchronous memory.
`timescale 1ns / 1ps

// Ordered key queue of up to QUEUE_DEPTH 14-bit keys, oldest at position 0.
// A push beat (kind 0) appends the key at the back or reports full; a remove
// beat (kind 1) searches from the newest entry towards the oldest for the key,
// takes the newest match out and closes the gap, reporting how many older
// entries stood ahead of it. Every input beat yields exactly one result beat.
// The keys live in a single memory with one write port and one registered
// read port; a small sequencer walks it one entry per cycle. One item is in
// work at a time. A push goes from acceptance straight to the finish state.
// A remove reads entries during the search, newest first, until it hits or
// has read the oldest entry, then moves each newer entry down one place to
// close the gap, then finishes. The search and the compaction both go
// through the one read port, one entry a cycle. The finished result sits in
// an output register, and the next beat is taken as soon as the sequencer
// is idle, even while that result still waits. Entries come up undefined
// after reset; only the state, the occupancy count and the output valid are
// cleared, and no entry beyond the occupancy count is ever read.
module queue_remove_by_key
    import qrk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [KEY_W-1:0]    plate,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [MOVED_W-1:0]  moved_count,
    output logic [OCC_W-1:0]    occupancy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Key store and its registered read port.
    logic [KEY_W-1:0] mem [QUEUE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // Sequencer state.
    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [MOVED_W-1:0]  pend_moved_reg, pend_moved_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [MOVED_W-1:0]  moved_reg, moved_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic [7:0] cnt8;
    logic [7:0] idx8;
    logic       in_beat;
    logic       out_free;

    assign cnt8     = 8'(count_reg);
    assign idx8     = 8'(idx_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Saturate a position to the width of moved_count.
    function automatic logic [MOVED_W-1:0] sat_moved(input logic [IDX_W-1:0] pos);
        logic [7:0] ext;
        ext = 8'(pos);
        sat_moved = (ext > 8'd7) ? 3'd7 : ext[MOVED_W-1:0];
    endfunction

    // Saturate the entry count to the width of occupancy.
    function automatic logic [OCC_W-1:0] sat_occ(input logic [CNT_W-1:0] cnt);
        logic [7:0] ext;
        ext = 8'(cnt);
        sat_occ = (ext > 8'd15) ? 4'd15 : ext[OCC_W-1:0];
    endfunction

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        key_next         = key_reg;
        pend_status_next = pend_status_reg;
        pend_moved_next  = pend_moved_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        moved_next       = moved_reg;
        occ_next         = occ_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = key_reg;
        mem_raddr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    key_next        = plate;
                    pend_moved_next = '0;
                    if (kind == KIND_PUSH)
                    begin
                        // Append at the back unless every slot is taken.
                        if (cnt8 >= 8'(QUEUE_DEPTH))
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = IDX_W'(cnt8);
                            mem_wdata        = plate;
                            count_next       = count_reg + CNT_W'(1);
                            pend_status_next = ST_PUSHED;
                        end
                        state_next = S_FINISH;
                    end
                    else if (cnt8 == 8'd0)
                    begin
                        pend_status_next = ST_NOT_FOUND;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        // Start the search at the newest entry.
                        mem_raddr  = IDX_W'(cnt8 - 8'd1);
                        idx_next   = IDX_W'(cnt8 - 8'd1);
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // rd_data_reg holds the entry at idx_reg.
                if (rd_data_reg == key_reg)
                begin
                    pend_moved_next  = sat_moved(idx_reg);
                    pend_status_next = (idx8 == 8'd0) ? ST_REMOVED_FRONT : ST_REMOVED_MOVED;
                    if (idx8 + 8'd1 < cnt8)
                    begin
                        // Fetch the next newer entry to move down into the gap.
                        mem_raddr  = IDX_W'(idx8 + 8'd1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
                else if (idx8 == 8'd0)
                begin
                    pend_status_next = ST_NOT_FOUND;
                    state_next       = S_FINISH;
                end
                else
                begin
                    mem_raddr = IDX_W'(idx8 - 8'd1);
                    idx_next  = IDX_W'(idx8 - 8'd1);
                end
            end

            S_SHIFT:
            begin
                // Move entry idx_reg + 1 down to idx_reg, fetch the one after.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                if (idx8 + 8'd2 < cnt8)
                begin
                    mem_raddr = IDX_W'(idx8 + 8'd2);
                    idx_next  = IDX_W'(idx8 + 8'd1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hold until the output register can take the result.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    moved_next     = pend_moved_reg;
                    occ_next       = sat_occ(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        key_reg         <= key_next;
        pend_status_reg <= pend_status_next;
        pend_moved_reg  <= pend_moved_next;
        status_reg      <= status_next;
        moved_reg       <= moved_next;
        occ_reg         <= occ_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign moved_count = moved_reg;
    assign occupancy   = occ_reg;

endmodule

[sv/qrk_checker.sv]
// Port-level checker for the ordered key queue, bound to the top level.
`timescale 1ns / 1ps

module qrk_checker
    import qrk_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [MOVED_W-1:0]  moved_count,
    input logic [OCC_W-1:0]    occupancy
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(moved_count) && $stable(occupancy))
        else $error("result beat changed while stalled");

    // Only a removal after moves reports a non-zero move count.
    a_moved_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_REMOVED_MOVED) == (moved_count != 3'd0)))
        else $error("moved_count does not match status");

    // A rejected push means the queue is at capacity.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(OCC_FULL))
        else $error("full reported below capacity");

    // A successful push leaves at least one entry and never exceeds capacity.
    a_push_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_PUSHED |-> occupancy != 4'd0
            && occupancy <= OCC_W'(OCC_FULL))
        else $error("occupancy out of range after push");

endmodule

bind queue_remove_by_key qrk_checker u_qrk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .moved_count (moved_count),
    .occupancy   (occupancy)
);

[test/tb_queue_remove_by_key.sv]
// Testbench for queue_remove_by_key: directed and random beats against a predictor.
`timescale 1ns / 1ps

// The bench drives push and remove beats into the ordered key queue and keeps
// its own model of the held plates. Every accepted input beat yields one
// expected result, which joins a FIFO. A separate checker pops that FIFO on
// each result beat and compares status, moved_count and occupancy field by
// field. Both handshakes idle at random, except for one stretch of the random
// traffic where neither side idles. All inputs are driven with nonblocking
// assignments at the rising edge. Handshakes are sampled at the same edge,
// before those assignments take effect.
module tb_queue_remove_by_key;

    import qrk_pkg::*;

    // Drain wait, covering the worst remove at depth 8 with a margin on top.
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_BEATS  = 1050;
    localparam int IDLE_PCT      = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MOVED_W-1:0]  moved;
        logic [OCC_W-1:0]    occ;
    } gate_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                kind      = KIND_PUSH;
    logic [KEY_W-1:0]    plate     = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [MOVED_W-1:0]  moved_count;
    logic [OCC_W-1:0]    occupancy;

    // Model of the queue contents, oldest plate at index 0.
    logic [KEY_W-1:0] held_plates[$];
    // Results owed by the block, oldest first.
    gate_result_t     pending_results[$];
    int               mismatches = 0;
    // When set, neither side idles.
    bit               steady     = 1'b0;

    // Keys that recur often, so that duplicates and hits are common.
    logic [KEY_W-1:0] plate_pool[6] = '{14'd0, 14'd1, 14'd9999, 14'd10000, 14'h3FFF, 14'd4242};

    queue_remove_by_key u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .plate       (plate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .moved_count (moved_count),
        .occupancy   (occupancy)
    );

    always #10 clk = ~clk;

    // Apply one accepted beat to the model and queue the result it must give.
    task automatic apply_plate_beat(input logic k, input logic [KEY_W-1:0] p);
        gate_result_t r;
        int           pos;
        r   = '0;
        pos = -1;
        if (k == KIND_PUSH)
        begin
            if (held_plates.size() >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                held_plates.push_back(p);
                r.status = ST_PUSHED;
            end
        end
        else
        begin
            // Search newest to oldest, so the newest duplicate goes first.
            for (int i = held_plates.size() - 1; i >= 0 && pos < 0; i--)
            begin
                if (held_plates[i] == p)
                    pos = i;
            end
            if (pos < 0)
            begin
                r.status = ST_NOT_FOUND;
            end
            else
            begin
                held_plates.delete(pos);
                r.status = (pos == 0) ? ST_REMOVED_FRONT : ST_REMOVED_MOVED;
                r.moved  = (pos > 7) ? 3'd7 : MOVED_W'(pos);
            end
        end
        r.occ = (held_plates.size() > 15) ? 4'd15 : OCC_W'(held_plates.size());
        pending_results.push_back(r);
    endtask

    // Offer one beat, idling first at random outside the steady stretch, and hold it until accepted.
    // Valid stays high afterwards so a following beat can go back to back.
    task automatic send_beat(input logic k, input logic [KEY_W-1:0] p);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        kind     <= k;
        plate    <= p;
        do
            @(posedge clk);
        while (!in_ready);
        apply_plate_beat(k, p);
    endtask

    // Drop valid, hold off until every owed result has come back, then wait DRAIN_CYCLES more.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Receiver side: stall at random unless in the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every result beat against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        gate_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result with none owed: status %0d moved %0d occ %0d",
                                       status, moved_count, occupancy));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || moved_count !== want.moved
                    || occupancy !== want.occ)
                    note_failure($sformatf(
                        "mismatch: expected status %0d moved %0d occ %0d, got %0d %0d %0d",
                        want.status, want.moved, want.occ, status, moved_count, occupancy));
            end
        end
    end

    // Removal from an empty queue must report not found.
    task automatic test_empty_remove();
        send_beat(KIND_REMOVE, 14'd5);
    endtask

    // Fill with extremes and a duplicate, then push twice into a full queue.
    task automatic test_fill_to_full();
        send_beat(KIND_PUSH, 14'd0);
        send_beat(KIND_PUSH, 14'h3FFF);
        send_beat(KIND_PUSH, 14'd9999);
        send_beat(KIND_PUSH, 14'd10000);
        send_beat(KIND_PUSH, 14'h3FFF);
        send_beat(KIND_PUSH, 14'd42);
        send_beat(KIND_PUSH, 14'h2AAA);
        send_beat(KIND_PUSH, 14'h1555);
        send_beat(KIND_PUSH, 14'd7);
        send_beat(KIND_PUSH, 14'd0);
    endtask

    // Newest entry (seven ahead), newest duplicate, front, a miss, reuse of a
    // freed slot, then the older duplicate now at the front.
    task automatic test_removal_cases();
        send_beat(KIND_REMOVE, 14'h1555);
        send_beat(KIND_REMOVE, 14'h3FFF);
        send_beat(KIND_REMOVE, 14'd0);
        send_beat(KIND_REMOVE, 14'd1234);
        send_beat(KIND_PUSH,   14'd77);
        send_beat(KIND_REMOVE, 14'h3FFF);
    endtask

    // Stop sending until the block has answered everything, then resume.
    task automatic test_sender_pause();
        send_beat(KIND_PUSH, 14'd300);
        send_beat(KIND_PUSH, 14'd301);
        wait_drained();
        send_beat(KIND_REMOVE, 14'd300);
    endtask

    // Random traffic. The push share changes every 64 beats so the queue
    // wanders between empty and full; keys mostly come from the held plates
    // or a small pool so that removals hit, with some fully random keys.
    task automatic test_random_traffic();
        int               push_pct;
        int               pick;
        logic             k;
        logic [KEY_W-1:0] p;
        push_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 64 == 0)
                push_pct = 25 + 25 * $urandom_range(2);
            steady <= (n >= 400 && n < 550);
            pick = $urandom_range(99);
            if (held_plates.size() != 0 && pick < 35)
                p = held_plates[$urandom_range(held_plates.size() - 1)];
            else if (pick < 85)
                p = plate_pool[$urandom_range(5)];
            else
                p = KEY_W'($urandom_range(16383));
            k = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_REMOVE;
            send_beat(k, p);
        end
        steady <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_remove();
        test_fill_to_full();
        test_removal_cases();
        test_sender_pause();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0)
            $display("tb_queue_remove_by_key: PASS");
        else
            $display("tb_queue_remove_by_key: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("tb_queue_remove_by_key: FAIL");
        $finish;
    end

endmodule
